[hdl/lpfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants shared by the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LENGTH_W = 24;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned STATUS_W = 2;

   localparam logic [LENGTH_W-1:0] HEADER_SIZE = LENGTH_W'(5);

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic                has_payload;
      logic                frame_end;
      logic [STATUS_W-1:0] frame_status;
      logic                type_invalid;
      logic [BYTE_W-1:0]   frame_type;
   } result_type;

endpackage

[hdl/length_prefixed_frame_deframer.sv]
`timescale 1ns / 1ps
// Path: a byte is held in the input register, and its result then in the
//   result register.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or being taken.
// Reset: synchronous, active high; clears both valid flags and frame state.
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Deframes a byte stream of length-prefixed frames with an XOR check byte,
// passing payload bytes on and reporting the status at each frame end.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_payload,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_frame_status,
   output logic       rsp_type_invalid,
   output logic [7:0] rsp_frame_type
);
   import lpfd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              advance;
   logic              in_take;
   result_type        result;
   result_type        out_ff;
   logic              out_valid_ff, out_valid_in;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   lpfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_has_payload  = out_ff.has_payload;
   assign rsp_frame_end    = out_ff.frame_end;
   assign rsp_frame_status = out_ff.frame_status;
   assign rsp_type_invalid = out_ff.type_invalid;
   assign rsp_frame_type   = out_ff.frame_type;

   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_frame_status == STATUS_OK)
      else $error("status reported outside frame end");

   a_short_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == STATUS_SHORT |-> !rsp_has_payload)
      else $error("short frame carries payload");

   a_stall_held_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

[hdl/lpfd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_core
// Frame state and next-state logic: walks the header, counts payload bytes,
// accumulates the XOR check and forms the result of each byte.
// ----------------------------------------------------------------------------
module lpfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output lpfd_pkg::result_type  result
);
   import lpfd_pkg::*;

   localparam logic [POS_W-1:0] POS_LEN0    = 3'd0;
   localparam logic [POS_W-1:0] POS_LEN1    = 3'd1;
   localparam logic [POS_W-1:0] POS_LEN2    = 3'd2;
   localparam logic [POS_W-1:0] POS_TYPE    = 3'd3;
   localparam logic [POS_W-1:0] POS_CHECK   = 3'd4;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd5;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [LENGTH_W-1:0] remaining_ff, remaining_in;
   logic [BYTE_W-1:0]   type_ff, type_in;
   logic [BYTE_W-1:0]   check_ff, check_in;
   logic [BYTE_W-1:0]   xor_ff, xor_in;
   logic [BYTE_W-1:0]   xor_next;

   assign xor_next = xor_ff ^ rx_byte;

   always_comb begin
      pos_in       = pos_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      type_in      = type_ff;
      check_in     = check_ff;
      xor_in       = xor_ff;

      result.valid        = 1'b0;
      result.payload_byte = '0;
      result.has_payload  = 1'b0;
      result.frame_end    = 1'b0;
      result.frame_status = STATUS_OK;
      result.type_invalid = (type_ff > 8'd1);
      result.frame_type   = type_ff;

      case (pos_ff)
         POS_LEN1, POS_LEN2: begin
            length_in = {length_ff[LENGTH_W-BYTE_W-1:0], rx_byte};
            pos_in    = pos_ff + 3'd1;
         end
         POS_TYPE: begin
            type_in = rx_byte;
            pos_in  = POS_CHECK;
         end
         POS_CHECK: begin
            check_in = rx_byte;
            xor_in   = '0;
            if (length_ff < HEADER_SIZE) begin
               remaining_in        = '0;
               pos_in              = POS_LEN0;
               result.valid        = 1'b1;
               result.frame_end    = 1'b1;
               result.frame_status = STATUS_SHORT;
            end else begin
               remaining_in = length_ff - HEADER_SIZE;
               if (length_ff == HEADER_SIZE) begin
                  pos_in              = POS_LEN0;
                  result.valid        = 1'b1;
                  result.frame_end    = 1'b1;
                  result.frame_status = (rx_byte != '0) ? STATUS_CHECKSUM : STATUS_OK;
               end else begin
                  pos_in = POS_PAYLOAD;
               end
            end
         end
         POS_PAYLOAD: begin
            xor_in              = xor_next;
            remaining_in        = remaining_ff - LENGTH_W'(1);
            result.valid        = 1'b1;
            result.payload_byte = rx_byte;
            result.has_payload  = 1'b1;
            if (remaining_ff == LENGTH_W'(1)) begin
               pos_in              = POS_LEN0;
               result.frame_end    = 1'b1;
               result.frame_status = (xor_next != check_ff) ? STATUS_CHECKSUM : STATUS_OK;
            end
         end
         default: begin
            length_in = {{(LENGTH_W-BYTE_W){1'b0}}, rx_byte};
            pos_in    = POS_LEN1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_LEN0;
         length_ff    <= '0;
         remaining_ff <= '0;
         type_ff      <= '0;
         check_ff     <= '0;
         xor_ff       <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         type_ff      <= type_in;
         check_ff     <= check_in;
         xor_ff       <= xor_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_PAYLOAD)
      else $error("header position out of range");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_PAYLOAD |-> remaining_ff != '0)
      else $error("payload phase with no bytes remaining");

   a_length_first_byte: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_LEN1 |-> length_ff[LENGTH_W-1:BYTE_W] == '0)
      else $error("stale length bits after first length byte");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed frame deframer. Streams short
// directed frames, then random frames: good, corrupted, short and with odd
// types. Both channels idle at random. A byte-level model predicts every
// result, and each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   import lpfd_pkg::*;

   localparam logic [POS_W-1:0] POS_LEN_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_LEN_MID = 3'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 3'd2;
   localparam logic [POS_W-1:0] POS_TYPE    = 3'd3;
   localparam logic [POS_W-1:0] POS_CHECK   = 3'd4;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd5;

   localparam int unsigned RANDOM_BYTES = 1450;
   localparam int unsigned IDLE_PERCENT = 27;

   class deframe_scoreboard;
      result_type          expected_q[$];
      int unsigned         mismatches = 0;
      logic [POS_W-1:0]    hdr_pos    = POS_LEN_HI;
      logic [LENGTH_W-1:0] flen       = '0;
      logic [LENGTH_W-1:0] remaining  = '0;
      logic [BYTE_W-1:0]   ftype      = '0;
      logic [BYTE_W-1:0]   chk        = '0;
      logic [BYTE_W-1:0]   xacc       = '0;

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         result_type r;
         bit         emits;
         r = '0;
         r.valid = 1'b1;
         emits = 1'b0;
         case (hdr_pos)
            POS_LEN_MID, POS_LEN_LO: begin
               flen = {flen[15:0], b};
               hdr_pos = hdr_pos + 3'd1;
            end
            POS_TYPE: begin
               ftype = b;
               hdr_pos = POS_CHECK;
            end
            POS_CHECK: begin
               chk = b;
               xacc = '0;
               if (flen < HEADER_SIZE) begin
                  remaining = '0;
                  hdr_pos = POS_LEN_HI;
                  emits = 1'b1;
                  r.frame_end = 1'b1;
                  r.frame_status = STATUS_SHORT;
               end else begin
                  remaining = flen - HEADER_SIZE;
                  if (remaining == '0) begin
                     hdr_pos = POS_LEN_HI;
                     emits = 1'b1;
                     r.frame_end = 1'b1;
                     r.frame_status = (chk != '0) ? STATUS_CHECKSUM : STATUS_OK;
                  end else begin
                     hdr_pos = POS_PAYLOAD;
                  end
               end
            end
            POS_PAYLOAD: begin
               xacc = xacc ^ b;
               remaining = remaining - 1'b1;
               emits = 1'b1;
               r.payload_byte = b;
               r.has_payload = 1'b1;
               if (remaining == '0) begin
                  hdr_pos = POS_LEN_HI;
                  r.frame_end = 1'b1;
                  r.frame_status = (xacc != chk) ? STATUS_CHECKSUM : STATUS_OK;
               end
            end
            default: begin
               flen = {16'd0, b};
               hdr_pos = POS_LEN_MID;
            end
         endcase
         if (emits) begin
            r.type_invalid = (ftype > 8'd1);
            r.frame_type = ftype;
            expected_q = {expected_q, r};
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual byte %0d end %0d",
                     $time, got.payload_byte, got.frame_end);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("has_payload", want.has_payload, got.has_payload);
         compare_field("frame_end", want.frame_end, got.frame_end);
         compare_field("frame_status", want.frame_status, got.frame_status);
         compare_field("type_invalid", want.type_invalid, got.type_invalid);
         compare_field("frame_type", want.frame_type, got.frame_type);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_payload;
   logic       rsp_frame_end;
   logic [1:0] rsp_frame_status;
   logic       rsp_type_invalid;
   logic [7:0] rsp_frame_type;

   deframe_scoreboard sb;
   bit                no_idle;
   bit                holdoff_request;
   int unsigned       bytes_sent;

   always #10 clock = ~clock;

   length_prefixed_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status),
      .rsp_type_invalid (rsp_type_invalid),
      .rsp_frame_type   (rsp_frame_type)
   );

   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input int unsigned len, input logic [7:0] ftype,
                             input bit corrupt);
      logic [7:0]  body[$];
      logic [7:0]  chk;
      logic [23:0] flen;
      flen = len[23:0];
      chk = '0;
      for (int unsigned i = 5; i < len; i++) begin
         body = {body, 8'($urandom_range(0, 255))};
         chk = chk ^ body[$];
      end
      if (corrupt || len < 5)
         chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(flen[23:16]);
      send_byte(flen[15:8]);
      send_byte(flen[7:0]);
      send_byte(ftype);
      send_byte(chk);
      foreach (body[i])
         send_byte(body[i]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // receiver: take results, stall at random or hold off on request
   initial begin
      result_type  got;
      int unsigned holdoff_left;
      holdoff_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '0;
            got.valid = 1'b1;
            got.payload_byte = rsp_payload_byte;
            got.has_payload = rsp_has_payload;
            got.frame_end = rsp_frame_end;
            got.frame_status = rsp_frame_status;
            got.type_invalid = rsp_type_invalid;
            got.frame_type = rsp_frame_type;
            sb.check_result(got);
         end
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoff_left = 300;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   initial begin
      logic [7:0]  opening_bytes[$];
      int unsigned pick;
      int unsigned len;
      int unsigned limit;
      bit          holdoff_done;
      bit          drain_done;
      logic [7:0]  ftype;
      opening_bytes = '{
         8'h00, 8'h00, 8'h04, 8'h00, 8'hFF,
         8'h00, 8'h00, 8'h05, 8'h01, 8'h00,
         8'h00, 8'h00, 8'h05, 8'hFF, 8'hA5,
         8'h00, 8'h00, 8'h07, 8'h02, 8'hFF, 8'hFF, 8'h00,
         8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 8'h5A
      };
      sb = new;
      no_idle = 1'b0;
      holdoff_request = 1'b0;
      bytes_sent = 0;
      holdoff_done = 1'b0;
      drain_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[i])
         send_byte(opening_bytes[i]);

      limit = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < limit) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            len = $urandom_range(0, 4);
         else if (pick < 16)
            len = 5;
         else if (pick < 96)
            len = $urandom_range(6, 24);
         else
            len = $urandom_range(25, 300);
         if ($urandom_range(0, 99) < 70)
            ftype = 8'($urandom_range(0, 1));
         else
            ftype = 8'($urandom_range(0, 255));
         send_frame(len, ftype, $urandom_range(0, 99) < 20);

         if (!holdoff_done && bytes_sent > 400) begin
            holdoff_done = 1'b1;
            holdoff_request = 1'b1;
         end
         if (!drain_done && bytes_sent > 800) begin
            drain_done = 1'b1;
            drain_results();
         end
         no_idle = (bytes_sent > 1000) && (bytes_sent < 1250);
      end
      no_idle = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("length_prefixed_frame_deframer test passed");
      else
         $display("length_prefixed_frame_deframer test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("length_prefixed_frame_deframer test failed");
      $finish;
   end

endmodule
